[rtl/ngd_pkg.sv]
// Package: constants shared by the normals geometric distance pipeline.
`timescale 1ns / 1ps
package ngd_pkg;

    localparam int NORM_W    = 16;   // Q1.15 normal component
    localparam int CENT_W    = 32;   // Q16.16 centroid coordinate
    localparam int DIST_W    = 17;   // Q1.16 result, 65536 = 1.0
    localparam int IN_DATA_W = 6 * NORM_W + 6 * CENT_W;
    localparam int OUT_DATA_W = 24;

    localparam int PRE_STAGES  = 8;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 19;
    localparam int POST_STAGES = 3;
    localparam int LATENCY     = PRE_STAGES + SQRT_STEPS + 1 + DIV_STEPS + POST_STAGES;

    // floor(s / 3) == (s * RECIP3) >> RECIP3_SH for s < 2^23
    localparam logic [21:0] RECIP3    = 22'd2796203;
    localparam int          RECIP3_SH = 23;
    localparam logic [DIST_W-1:0] DIST_MAX = 17'd65536;

endpackage

[rtl/normals_geometric_distance_top.sv]
// Top level: pipelined geometric distance between two surface patches.
//
// Usage:
//   Slave stream s_axis_* carries one patch pair per transfer (two normals,
//   two centroids). Master stream m_axis_* returns one distance per pair,
//   with the coinciding-centroid flag on tuser.
//   One pair can enter every cycle while the receiver keeps up; the chain is
//   8 arithmetic stages, a 32-step square root array (cross term and centroid
//   length side by side), a 19-step restoring divider pair for the dot terms,
//   and 3 stages for the mean.
//   Reset clears all valid bits; the pipeline comes up empty and ready.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is dropped or repeated.
`timescale 1ns / 1ps
module normals_geometric_distance_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // n1_x, n1_y, n1_z, c1_x, c1_y, c1_z, n2_x, n2_y, n2_z, c2_x, c2_y, c2_z
    input  logic [ngd_pkg::IN_DATA_W-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // geometric_distance, zero pad
    output logic [ngd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // centroids_coincide
    output logic        m_axis_tuser
);

    localparam int LAT = ngd_pkg::LATENCY;
    localparam int SQ  = ngd_pkg::SQRT_STEPS;
    localparam int DV  = ngd_pkg::DIV_STEPS;

    logic adv;
    logic [LAT-1:0] vp_reg;

    assign adv           = !vp_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vp_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_reg <= '0;
        end
        else if (adv)
        begin
            vp_reg <= {vp_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // ---------------- S1: unpack, centroid difference
    logic signed [15:0] a_next [0:2];
    logic signed [15:0] b_next [0:2];
    logic signed [32:0] d_next [0:2];
    logic signed [15:0] a1_reg [0:2];
    logic signed [15:0] b1_reg [0:2];
    logic signed [32:0] d1_reg [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a_next[k] = $signed(s_axis_tdata[16*k +: 16]);
            b_next[k] = $signed(s_axis_tdata[144 + 16*k +: 16]);
            d_next[k] = $signed({s_axis_tdata[192 + 32*k + 31], s_axis_tdata[192 + 32*k +: 32]})
                      - $signed({s_axis_tdata[48 + 32*k + 31], s_axis_tdata[48 + 32*k +: 32]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a1_reg <= a_next;
            b1_reg <= b_next;
            d1_reg <= d_next;
        end
    end

    // ---------------- S2: cross products, difference magnitudes
    logic signed [31:0] pr_next [0:5];
    logic [31:0]        dm_next [0:2];
    logic signed [31:0] pr2_reg [0:5];
    logic [31:0]        dm2_reg [0:2];
    logic [2:0]         dneg2_reg;
    logic               co2_reg;
    logic signed [15:0] a2_reg [0:2];
    logic signed [15:0] b2_reg [0:2];

    always_comb
    begin
        pr_next[0] = 32'(a1_reg[1]) * 32'(b1_reg[2]);
        pr_next[1] = 32'(a1_reg[2]) * 32'(b1_reg[1]);
        pr_next[2] = 32'(a1_reg[2]) * 32'(b1_reg[0]);
        pr_next[3] = 32'(a1_reg[0]) * 32'(b1_reg[2]);
        pr_next[4] = 32'(a1_reg[0]) * 32'(b1_reg[1]);
        pr_next[5] = 32'(a1_reg[1]) * 32'(b1_reg[0]);
        for (int k = 0; k < 3; k++)
        begin
            dm_next[k] = d1_reg[k][32] ? 32'(-d1_reg[k]) : d1_reg[k][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pr2_reg   <= pr_next;
            dm2_reg   <= dm_next;
            dneg2_reg <= {d1_reg[2][32], d1_reg[1][32], d1_reg[0][32]};
            co2_reg   <= (d1_reg[0] == '0) && (d1_reg[1] == '0) && (d1_reg[2] == '0);
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
        end
    end

    // ---------------- S3: cross components, max magnitude
    logic signed [32:0] x_next [0:2];
    logic [31:0]        xm_next [0:2];
    logic [31:0]        mx_next;
    logic [31:0]        xm3_reg [0:2];
    logic [31:0]        mx3_reg;
    logic [31:0]        dm3_reg [0:2];
    logic [2:0]         dneg3_reg;
    logic               co3_reg;
    logic signed [15:0] a3_reg [0:2];
    logic signed [15:0] b3_reg [0:2];

    always_comb
    begin
        x_next[0] = 33'(pr2_reg[0]) - 33'(pr2_reg[1]);
        x_next[1] = 33'(pr2_reg[2]) - 33'(pr2_reg[3]);
        x_next[2] = 33'(pr2_reg[4]) - 33'(pr2_reg[5]);
        for (int k = 0; k < 3; k++)
        begin
            xm_next[k] = x_next[k][32] ? 32'(-x_next[k]) : x_next[k][31:0];
        end
        mx_next = dm2_reg[0];
        if (dm2_reg[1] > mx_next)
        begin
            mx_next = dm2_reg[1];
        end
        if (dm2_reg[2] > mx_next)
        begin
            mx_next = dm2_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xm3_reg   <= xm_next;
            mx3_reg   <= mx_next;
            dm3_reg   <= dm2_reg;
            dneg3_reg <= dneg2_reg;
            co3_reg   <= co2_reg;
            a3_reg    <= a2_reg;
            b3_reg    <= b2_reg;
        end
    end

    // ---------------- S4: cross squares, normalize shift amount
    logic [4:0]         msb_next;
    logic [4:0]         ls_next;
    logic [1:0]         rs_next;
    logic [63:0]        xsq4_reg [0:2];
    logic [4:0]         ls4_reg;
    logic [1:0]         rs4_reg;
    logic [31:0]        dm4_reg [0:2];
    logic [2:0]         dneg4_reg;
    logic               co4_reg;
    logic signed [15:0] a4_reg [0:2];
    logic signed [15:0] b4_reg [0:2];

    always_comb
    begin
        msb_next = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (mx3_reg[i])
            begin
                msb_next = 5'(i);
            end
        end
        if (msb_next >= 5'd29)
        begin
            ls_next = '0;
            rs_next = 2'(msb_next - 5'd29);
        end
        else
        begin
            ls_next = 5'd29 - msb_next;
            rs_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                xsq4_reg[k] <= 64'(xm3_reg[k]) * 64'(xm3_reg[k]);
            end
            ls4_reg   <= ls_next;
            rs4_reg   <= rs_next;
            dm4_reg   <= dm3_reg;
            dneg4_reg <= dneg3_reg;
            co4_reg   <= co3_reg;
            a4_reg    <= a3_reg;
            b4_reg    <= b3_reg;
        end
    end

    // ---------------- S5: cross sum of squares, scaled difference
    logic [63:0]        sh_next [0:2];
    logic [63:0]        cs5_reg;
    logic [29:0]        dms5_reg [0:2];
    logic [2:0]         dneg5_reg;
    logic               co5_reg;
    logic signed [15:0] a5_reg [0:2];
    logic signed [15:0] b5_reg [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sh_next[k] = (64'(dm4_reg[k]) << ls4_reg) >> rs4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cs5_reg <= xsq4_reg[0] + xsq4_reg[1] + xsq4_reg[2];
            for (int k = 0; k < 3; k++)
            begin
                dms5_reg[k] <= sh_next[k][29:0];
            end
            dneg5_reg <= dneg4_reg;
            co5_reg   <= co4_reg;
            a5_reg    <= a4_reg;
            b5_reg    <= b4_reg;
        end
    end

    // ---------------- S6: difference squares, normal-by-difference products
    logic signed [30:0] ds_next [0:2];
    logic [59:0]        dsq6_reg [0:2];
    logic signed [46:0] pa6_reg [0:2];
    logic signed [46:0] pb6_reg [0:2];
    logic [63:0]        cs6_reg;
    logic               co6_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ds_next[k] = dneg5_reg[k] ? -$signed({1'b0, dms5_reg[k]})
                                      :  $signed({1'b0, dms5_reg[k]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dsq6_reg[k] <= 60'(dms5_reg[k]) * 60'(dms5_reg[k]);
                pa6_reg[k]  <= 47'(a5_reg[k]) * 47'(ds_next[k]);
                pb6_reg[k]  <= 47'(b5_reg[k]) * 47'(ds_next[k]);
            end
            cs6_reg <= cs5_reg;
            co6_reg <= co5_reg;
        end
    end

    // ---------------- S7: length squared, dot products
    logic [63:0]        ss7_reg;
    logic signed [47:0] p17_reg;
    logic signed [47:0] p27_reg;
    logic [63:0]        cs7_reg;
    logic               co7_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ss7_reg <= 64'(dsq6_reg[0]) + 64'(dsq6_reg[1]) + 64'(dsq6_reg[2]);
            p17_reg <= 48'(pa6_reg[0]) + 48'(pa6_reg[1]) + 48'(pa6_reg[2]);
            p27_reg <= 48'(pb6_reg[0]) + 48'(pb6_reg[1]) + 48'(pb6_reg[2]);
            cs7_reg <= cs6_reg;
            co7_reg <= co6_reg;
        end
    end

    // ---------------- S8 / square root array
    logic [63:0] cr_rem_reg  [0:SQ];
    logic [31:0] cr_root_reg [0:SQ];
    logic [63:0] dr_rem_reg  [0:SQ];
    logic [31:0] dr_root_reg [0:SQ];
    logic [46:0] pm1_reg     [0:SQ];
    logic [46:0] pm2_reg     [0:SQ];
    logic        sco_reg     [0:SQ];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_rem_reg[0]  <= cs7_reg;
            cr_root_reg[0] <= '0;
            dr_rem_reg[0]  <= ss7_reg;
            dr_root_reg[0] <= '0;
            pm1_reg[0]     <= p17_reg[47] ? 47'(-p17_reg) : p17_reg[46:0];
            pm2_reg[0]     <= p27_reg[47] ? 47'(-p27_reg) : p27_reg[46:0];
            sco_reg[0]     <= co7_reg;
        end
    end

    for (genvar g = 0; g < SQ; g++)
    begin : g_sqrt
        localparam int K = SQ - 1 - g;
        logic [63:0] ct;
        logic [63:0] dt;

        assign ct = ((64'(cr_root_reg[g]) << 1) + (64'd1 << K)) << K;
        assign dt = ((64'(dr_root_reg[g]) << 1) + (64'd1 << K)) << K;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (cr_rem_reg[g] >= ct)
                begin
                    cr_rem_reg[g+1]  <= cr_rem_reg[g] - ct;
                    cr_root_reg[g+1] <= cr_root_reg[g] | (32'd1 << K);
                end
                else
                begin
                    cr_rem_reg[g+1]  <= cr_rem_reg[g];
                    cr_root_reg[g+1] <= cr_root_reg[g];
                end
                if (dr_rem_reg[g] >= dt)
                begin
                    dr_rem_reg[g+1]  <= dr_rem_reg[g] - dt;
                    dr_root_reg[g+1] <= dr_root_reg[g] | (32'd1 << K);
                end
                else
                begin
                    dr_rem_reg[g+1]  <= dr_rem_reg[g];
                    dr_root_reg[g+1] <= dr_root_reg[g];
                end
                pm1_reg[g+1] <= pm1_reg[g];
                pm2_reg[g+1] <= pm2_reg[g];
                sco_reg[g+1] <= sco_reg[g];
            end
        end
    end

    // ---------------- divider array: dot terms = 2|p| / len
    logic [47:0] r1_reg  [0:DV];
    logic [47:0] r2_reg  [0:DV];
    logic [18:0] q1_reg  [0:DV];
    logic [18:0] q2_reg  [0:DV];
    logic [30:0] len_reg [0:DV];
    logic [17:0] cr_reg  [0:DV];
    logic        dco_reg [0:DV];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg[0]  <= {pm1_reg[SQ], 1'b0};
            r2_reg[0]  <= {pm2_reg[SQ], 1'b0};
            q1_reg[0]  <= '0;
            q2_reg[0]  <= '0;
            len_reg[0] <= dr_root_reg[SQ][30:0];
            cr_reg[0]  <= cr_root_reg[SQ][31:14];
            dco_reg[0] <= sco_reg[SQ];
        end
    end

    for (genvar j = 0; j < DV; j++)
    begin : g_div
        localparam int K = DV - 1 - j;
        logic [48:0] tr;

        assign tr = 49'(len_reg[j]) << K;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (49'(r1_reg[j]) >= tr)
                begin
                    r1_reg[j+1] <= 48'(49'(r1_reg[j]) - tr);
                    q1_reg[j+1] <= q1_reg[j] | (19'd1 << K);
                end
                else
                begin
                    r1_reg[j+1] <= r1_reg[j];
                    q1_reg[j+1] <= q1_reg[j];
                end
                if (49'(r2_reg[j]) >= tr)
                begin
                    r2_reg[j+1] <= 48'(49'(r2_reg[j]) - tr);
                    q2_reg[j+1] <= q2_reg[j] | (19'd1 << K);
                end
                else
                begin
                    r2_reg[j+1] <= r2_reg[j];
                    q2_reg[j+1] <= q2_reg[j];
                end
                len_reg[j+1] <= len_reg[j];
                cr_reg[j+1]  <= cr_reg[j];
                dco_reg[j+1] <= dco_reg[j];
            end
        end
    end

    // ---------------- mean of three terms, saturate
    logic [20:0] sum_reg;
    logic        sco_s_reg;
    logic [42:0] mul_reg;
    logic        sco_m_reg;
    logic [19:0] quo_next;
    logic [ngd_pkg::DIST_W-1:0] dist_reg;
    logic        co_out_reg;

    assign quo_next = mul_reg[ngd_pkg::RECIP3_SH +: 20];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sum_reg   <= 21'(cr_reg[DV])
                       + (dco_reg[DV] ? 21'd0 : 21'(q1_reg[DV]) + 21'(q2_reg[DV]));
            sco_s_reg <= dco_reg[DV];
            mul_reg   <= 43'(sum_reg) * 43'(ngd_pkg::RECIP3);
            sco_m_reg <= sco_s_reg;
            dist_reg  <= (quo_next > 20'(ngd_pkg::DIST_MAX)) ? ngd_pkg::DIST_MAX
                                                             : quo_next[16:0];
            co_out_reg <= sco_m_reg;
        end
    end

    assign m_axis_tdata = {{(ngd_pkg::OUT_DATA_W - ngd_pkg::DIST_W){1'b0}}, dist_reg};
    assign m_axis_tuser = co_out_reg;

endmodule
